/* rtl/core/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache model.
// No dependencies; imported by the cache top level.
package salc_pkg;

    // Field widths of the access and result beats
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 48;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_cnt CNT_MAX = {CNT_W{1'b1}};

    // Control state: metadata clearing pass, then normal lookups
    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

endpackage

/* rtl/core/salc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the array and register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/set_associative_lru_cache_top.sv */
// Top level of the set-associative LRU cache hit/miss model.
// Depends on salc_pkg and instantiates salc_ram for tags and set metadata.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one block address per beat.
//   The low SET_INDEX_BITS bits pick the set, the bits above up to
//   ADDRESS_BITS form the tag. Output channel (o_valid / i_stall) returns
//   one beat per access: hit, evicted, and the saturating hit and miss
//   totals including that access.
//   A beat accepted goes to the lookup stage, then to the output register
//   once it is free. Throughput: one access per cycle unless the output
//   stalls, also for back-to-back hits on one set; the tag and metadata RAMs
//   are read at accept and written as the lookup advances, and a forwarding
//   register covers the one write that can land with a read of the same set.
//   Reset: synchronous, active low. After reset the block runs a clearing
//   pass over the metadata RAM, one set per cycle, and holds o_stall high
//   until it ends. Tags are not cleared; they are only looked at for valid
//   lines.
//   Stall: while i_stall holds a result, one more access can be looked up
//   and then waits; after that o_stall rises until the result is taken.
module set_associative_lru_cache_top
    import salc_pkg::*;
#(
    parameter int SET_INDEX_BITS = 11,
    parameter int WAYS           = 4,
    parameter int ADDRESS_BITS   = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ADDR_W-1:0] i_block_address,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_hit,
    output logic              o_evicted,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_miss_total
);

    localparam int   EFF_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int   TAG_W    = (EFF_BITS > SET_INDEX_BITS) ? EFF_BITS - SET_INDEX_BITS : 1;
    localparam int   RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int   NUM_SETS = 1 << SET_INDEX_BITS;
    localparam int   META_W   = WAYS * (1 + RANK_W);
    localparam int   TROW_W   = WAYS * TAG_W;
    localparam t_addr AMASK   = t_addr'({ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS));
    localparam logic [RANK_W-1:0] OLDEST = RANK_W'(WAYS - 1);

    typedef logic [SET_INDEX_BITS-1:0]    t_set;
    typedef logic [TAG_W-1:0]             t_tag;
    typedef logic [WAYS-1:0][TAG_W-1:0]   t_tag_row;
    typedef logic [WAYS-1:0][RANK_W-1:0]  t_rank_row;

    t_state    r_state;
    t_set      r_clr_idx;

    logic      r_s1_vld;
    t_set      r_s1_set;
    t_tag      r_s1_tag;
    logic      r_fwd_vld;
    t_tag_row  r_fwd_tags;
    logic [WAYS-1:0] r_fwd_valid;
    t_rank_row r_fwd_rank;

    logic      r_out_vld;
    logic      r_hit;
    logic      r_evicted;
    t_cnt      r_hit_cnt;
    t_cnt      r_miss_cnt;

    t_addr     in_masked;
    t_addr     in_tag_full;
    t_set      in_set;
    t_tag      in_tag;
    logic      accept;
    logic      adv;

    logic [TROW_W-1:0] tag_q;
    logic [META_W-1:0] meta_q;
    logic [META_W-1:0] meta_wdata;
    logic              meta_we;
    t_set              meta_waddr;

    t_tag_row  row_tags;
    logic [WAYS-1:0] row_valid;
    t_rank_row row_rank;
    logic [WAYS-1:0] hit_vec;
    logic      s1_hit;
    logic      set_full;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] empty_way;
    logic [RANK_W-1:0] victim_way;
    logic [RANK_W-1:0] sel_way;
    logic [RANK_W-1:0] sel_rank;

    t_tag_row  n_tags;
    logic [WAYS-1:0] n_valid;
    t_rank_row n_rank;
    t_cnt      n_hit_cnt;
    t_cnt      n_miss_cnt;

    // Split the incoming address into set and tag
    always_comb begin
        in_masked   = i_block_address & AMASK;
        in_tag_full = in_masked >> SET_INDEX_BITS;
        in_set      = in_masked[SET_INDEX_BITS-1:0];
        in_tag      = in_tag_full[TAG_W-1:0];
    end

    // Handshake: hold the lookup stage until the output register frees up
    assign adv     = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = (r_state != ST_RUN) || (r_s1_vld && !adv);
    assign accept  = i_valid && !o_stall;

    // Tag store, one row of all ways per set
    salc_ram #(
        .WIDTH (TROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (adv),
        .i_waddr (r_s1_set),
        .i_wdata (n_tags),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (tag_q)
    );

    // Metadata store: valid bits and recency ranks per set
    assign meta_we    = (r_state == ST_CLEAR) || adv;
    assign meta_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_s1_set;
    assign meta_wdata = (r_state == ST_CLEAR) ? '0 : {n_valid, n_rank};

    salc_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (meta_q)
    );

    // Pick the set row: forwarded write or RAM data
    always_comb begin
        if (r_fwd_vld) begin
            row_tags  = r_fwd_tags;
            row_valid = r_fwd_valid;
            row_rank  = r_fwd_rank;
        end else begin
            row_tags  = tag_q;
            {row_valid, row_rank} = meta_q;
        end
    end

    // Compare tags and find the hit, empty and victim ways
    always_comb begin
        hit_way    = '0;
        empty_way  = '0;
        victim_way = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            hit_vec[k] = row_valid[k] && (row_tags[k] == r_s1_tag);
            if (hit_vec[k]) begin
                hit_way = RANK_W'(k);
            end
            if (!row_valid[k]) begin
                empty_way = RANK_W'(k);
            end
            if (row_rank[k] == OLDEST) begin
                victim_way = RANK_W'(k);
            end
        end
        s1_hit   = |hit_vec;
        set_full = &row_valid;
        if (s1_hit) begin
            sel_way = hit_way;
        end else if (set_full) begin
            sel_way = victim_way;
        end else begin
            sel_way = empty_way;
        end
        sel_rank = row_rank[sel_way];
    end

    // Build the updated row: promote the chosen way, age the newer lines
    always_comb begin
        n_tags  = row_tags;
        n_valid = row_valid;
        n_rank  = row_rank;
        for (int k = 0; k < WAYS; k++) begin
            if (RANK_W'(k) == sel_way) begin
                n_rank[k] = '0;
            end else if (row_valid[k] && (!s1_hit || (row_rank[k] < sel_rank))) begin
                n_rank[k] = row_rank[k] + 1'b1;
            end
        end
        if (!s1_hit) begin
            n_tags[sel_way]  = r_s1_tag;
            n_valid[sel_way] = 1'b1;
        end
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (s1_hit) begin
            if (r_hit_cnt != CNT_MAX) begin
                n_hit_cnt = r_hit_cnt + 1'b1;
            end
        end else if (r_miss_cnt != CNT_MAX) begin
            n_miss_cnt = r_miss_cnt + 1'b1;
        end
    end

    // Run the clearing pass, then hand over to lookups
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == t_set'(NUM_SETS - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    // Lookup stage control and result counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld  <= 1'b1;
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Capture the beat, forward a write that lands with its read, register the result flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_set    <= in_set;
            r_s1_tag    <= in_tag;
            r_fwd_vld   <= adv && (r_s1_set == in_set);
            r_fwd_tags  <= n_tags;
            r_fwd_valid <= n_valid;
            r_fwd_rank  <= n_rank;
        end
        if (adv) begin
            r_hit     <= s1_hit;
            r_evicted <= !s1_hit && set_full;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_hit        = r_hit;
    assign o_evicted    = r_evicted;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

`ifndef ASSERT_OFF
    // No access is taken while the metadata is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_stall)
        else $error("access accepted during clearing pass");

    // A finished lookup always shows up on the output
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_valid)
        else $error("lookup result lost");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted))
        else $error("hit reported with eviction");

    // A miss into a set with room does not evict
    a_fill_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !s1_hit && !set_full) |=> !o_evicted)
        else $error("eviction with an empty way");

    // A miss leaves exactly one more valid line in a set with room
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !s1_hit && !set_full) |->
            ($countones(n_valid) == $countones(row_valid) + 1))
        else $error("fill did not add one line");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for set_associative_lru_cache_top: 4-way true-LRU hit/miss tracking.
// Depends on salc_pkg and the cache top level; a shadow of the tag, valid and rank state
// predicts every result beat.
module tb_top
    import salc_pkg::*;
();

    localparam int SET_BITS   = 11;
    localparam int WAY_CNT    = 4;
    localparam int NUM_LINES  = (1 << SET_BITS) * WAY_CNT;
    localparam int TAG_W      = ADDR_W - SET_BITS;
    localparam int RAND_ITEMS = 1380;
    localparam int TAIL_ITEMS = 200;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic hit;
        logic evicted;
        t_cnt hit_total;
        t_cnt miss_total;
    } t_outcome;

    // Shadow of the cache state; predicts and checks one result per access
    class lru_tracker;
        bit [TAG_W-1:0] tag_mem   [NUM_LINES];
        bit             line_live [NUM_LINES];
        bit [7:0]       age       [NUM_LINES];
        t_cnt           hit_cnt;
        t_cnt           miss_cnt;
        t_outcome       pending_outcomes [$];
        int             errors;
        int             n_checked;
        int             n_hits;
        int             n_evictions;

        function new();
            hit_cnt     = '0;
            miss_cnt    = '0;
            errors      = 0;
            n_checked   = 0;
            n_hits      = 0;
            n_evictions = 0;
        endfunction

        // Make one way most recent; live lines younger than limit grow one rank older
        function void age_others(int base, int way, int limit);
            for (int k = 0; k < WAY_CNT; k++) begin
                if (k != way && line_live[base+k] && int'(age[base+k]) < limit)
                    age[base+k] = age[base+k] + 8'd1;
            end
            age[base+way] = 8'd0;
        endfunction

        function void note_access(t_addr addr);
            int             base;
            int             way;
            int             victim;
            bit [TAG_W-1:0] tag;
            t_outcome       o;
            base      = int'(addr[SET_BITS-1:0]) * WAY_CNT;
            tag       = addr[ADDR_W-1:SET_BITS];
            way       = -1;
            o.evicted = 1'b0;
            for (int k = 0; k < WAY_CNT; k++) begin
                if (way < 0 && line_live[base+k] && tag_mem[base+k] == tag)
                    way = k;
            end
            o.hit = (way >= 0);
            if (o.hit) begin
                if (hit_cnt != CNT_MAX)
                    hit_cnt = hit_cnt + 1'b1;
                age_others(base, way, int'(age[base+way]));
            end else begin
                if (miss_cnt != CNT_MAX)
                    miss_cnt = miss_cnt + 1'b1;
                // Fill the lowest empty way, else replace the oldest line
                for (int k = 0; k < WAY_CNT; k++) begin
                    if (way < 0 && !line_live[base+k])
                        way = k;
                end
                if (way < 0) begin
                    victim = 0;
                    for (int k = 1; k < WAY_CNT; k++) begin
                        if (age[base+k] > age[base+victim])
                            victim = k;
                    end
                    way       = victim;
                    o.evicted = 1'b1;
                end
                tag_mem[base+way]   = tag;
                line_live[base+way] = 1'b0;
                age_others(base, way, 256);
                line_live[base+way] = 1'b1;
            end
            o.hit_total  = hit_cnt;
            o.miss_total = miss_cnt;
            pending_outcomes.push_back(o);
        endfunction

        function void check_result(logic hit, logic evicted, t_cnt hit_total, t_cnt miss_total);
            t_outcome want;
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing pending: hit=%0b evicted=%0b", hit, evicted);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            n_checked++;
            if (want.hit)
                n_hits++;
            if (want.evicted)
                n_evictions++;
            if (hit !== want.hit) begin
                $error("hit: expected %0b, actual %0b", want.hit, hit);
                errors++;
            end
            if (evicted !== want.evicted) begin
                $error("evicted: expected %0b, actual %0b", want.evicted, evicted);
                errors++;
            end
            if (hit_total !== want.hit_total) begin
                $error("hit_total: expected %0d, actual %0d", want.hit_total, hit_total);
                errors++;
            end
            if (miss_total !== want.miss_total) begin
                $error("miss_total: expected %0d, actual %0d", want.miss_total, miss_total);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_addr      i_block_address;
    logic       o_valid;
    logic       i_stall;
    logic       o_hit;
    logic       o_evicted;
    t_cnt       o_hit_total;
    t_cnt       o_miss_total;

    lru_tracker tracker = new();
    bit         calm_tail = 1'b0;
    int         cycle_count = 0;

    set_associative_lru_cache_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_block_address (i_block_address),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_evicted       (o_evicted),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total)
    );

    // Generate the clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count cycles for the run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial begin
        wait (cycle_count >= LIMIT);
        $display("tb_top: timeout after %0d cycles", cycle_count);
        $display("tb_top: done, errors");
        $finish;
    end

    // Check every result beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result(o_hit, o_evicted, o_hit_total, o_miss_total);
    end

    // Stall the result side in random bursts, no new burst in the tail
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
                if (run_left > 0)
                    run_left--;
                else if (!calm_tail && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 16);
                else if ($urandom_range(0, 15) == 0)
                    run_left = $urandom_range(20, 80);
            end
        end
    end

    function automatic t_addr compose(bit [TAG_W-1:0] tag, bit [SET_BITS-1:0] set_idx);
        return {tag, set_idx};
    endfunction

    // Present one access and hold it until the block takes the beat
    task automatic send_access(t_addr addr);
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_block_address = addr;
        do
            @(posedge i_clk);
        while (o_stall);
        tracker.note_access(addr);
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    initial begin
        bit [SET_BITS-1:0] set_pool [8];
        bit [TAG_W-1:0]    tag_pool [6];
        bit [SET_BITS-1:0] cur_set;
        t_addr             addr;
        int                gap_odds;
        int                pick;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_block_address = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: address extremes, fill, hit promotion and LRU replacement
        send_access('0);
        send_access('1);
        send_access('0);
        send_access(compose(TAG_W'(1), SET_BITS'(5)));
        send_access(compose(TAG_W'(2), SET_BITS'(5)));
        send_access(compose(TAG_W'(3), SET_BITS'(5)));
        send_access(compose(TAG_W'(4), SET_BITS'(5)));
        send_access(compose(TAG_W'(1), SET_BITS'(5)));
        send_access(compose(TAG_W'(5), SET_BITS'(5)));
        send_access(compose(TAG_W'(2), SET_BITS'(5)));
        send_access(compose(TAG_W'(1), SET_BITS'(5)));
        send_access(compose(TAG_W'(4), SET_BITS'(5)));
        send_access(compose(TAG_W'(3), SET_BITS'(5)));
        send_access(compose('1, '0));
        send_access(compose(TAG_W'({(TAG_W+1)/2{2'b10}}), '0));
        send_access(compose(TAG_W'({(TAG_W+1)/2{2'b01}}), '0));
        send_access('0);
        send_access(compose(TAG_W'(7), '0));
        send_access(compose('1, '0));
        send_access(compose(TAG_W'({(TAG_W+1)/2{2'b10}}), '0));
        send_access('1);
        hold_off(3);

        // Random: mostly a small pool of sets and tags, some wide-open noise
        set_pool[0] = '0;
        set_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            set_pool[k] = SET_BITS'($urandom);
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int k = 2; k < 6; k++)
            tag_pool[k] = TAG_W'({$urandom, $urandom});
        cur_set  = set_pool[0];
        gap_odds = 0;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS - TAIL_ITEMS)
                calm_tail = 1'b1;
            if (i % 64 == 0)
                gap_odds = $urandom_range(0, 4);
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                addr = t_addr'({$urandom, $urandom});
            end else begin
                if ($urandom_range(0, 1) == 0)
                    cur_set = set_pool[$urandom_range(0, 7)];
                addr = compose(tag_pool[$urandom_range(0, 5)], cur_set);
            end
            send_access(addr);
            if (!calm_tail && gap_odds != 0 && $urandom_range(1, 16) <= gap_odds)
                hold_off($urandom_range(1, 16));
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        // Drain, then allow the pipeline latency
        while (tracker.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("tb_top: %0d result beats checked, %0d hits, %0d evictions",
                 tracker.n_checked, tracker.n_hits, tracker.n_evictions);
        $display("tb_top: %0d mismatches after %0d cycles", tracker.errors, cycle_count);
        if (tracker.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
